// ===== sv/lefd_pkg.sv =====
// Package: word types for the line endpoint block.
package lefd_pkg;

  localparam int unsigned CoordW = 32;

  typedef struct packed {
    logic                     operation;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
    logic signed [CoordW-1:0] seg_length;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_start_x;
    logic signed [CoordW-1:0] out_start_y;
    logic signed [CoordW-1:0] out_start_z;
    logic signed [CoordW-1:0] out_end_x;
    logic signed [CoordW-1:0] out_end_y;
    logic signed [CoordW-1:0] out_end_z;
  } out_word_t;

  localparam logic OpTwoPoint  = 1'b0;
  localparam logic OpDirection = 1'b1;

endpackage

// ===== sv/line_endpoint_from_direction.sv =====
// Top level: pipelined 3D line end point builder (fixed-point sqrt and divide).
//
// One word per cycle enters and one result word leaves per cycle unless the output stalls.
// The path runs through a 16-stage square-root pipeline (two root bits a stage) and a
// 16-stage restoring divider (two quotient bits a stage, one lane per axis). Coordinates
// are signed 32-bit fixed point; the fraction width does not enter the arithmetic since
// only ratios of like values are formed.
// The whole pipeline holds while the output word waits and out_stall_i is high.
module line_endpoint_from_direction (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lefd_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lefd_pkg::out_word_t  out_data_o
);

  localparam int unsigned SqStg  = 16;
  localparam int unsigned DivStg = 16;
  localparam int unsigned NStg   = 4 + SqStg + 1 + DivStg + 1;
  localparam int unsigned SqBase = 4;
  localparam int unsigned NumStg = SqBase + SqStg;
  localparam int unsigned OutStg = NStg - 1;

  typedef struct packed {
    logic             dmode;
    logic             zero;
    logic             len_pos;
    logic [2:0]       dneg;
    logic [2:0][31:0] st;
    logic [2:0][31:0] en;
    logic [2:0][31:0] d;
    logic [31:0]      len;
  } carry_t;

  logic            adv;
  logic [NStg-1:0] valid_q;
  carry_t          carry_d;
  carry_t          carry_q [NStg];

  logic [2:0][31:0] a_q;
  logic [30:0]      lenu_q;
  logic [2:0][63:0] sq_q;
  logic [2:0][62:0] p1_q, p2_q, p3_q;
  logic [63:0]      sxy_q, sz_q, s_q;

  logic [63:0]      sqv_q [SqStg];
  logic [63:0]      sqr_q [SqStg];
  logic [2:0][62:0] sqp_q [SqStg];

  logic [31:0]      mag_q;
  logic [2:0][62:0] n_q;

  logic [2:0][31:0] rem_q [DivStg];
  logic [2:0][31:0] quo_q [DivStg];
  logic [2:0][62:0] dn_q  [DivStg];
  logic [31:0]      dm_q  [DivStg];

  lefd_pkg::out_word_t out_q, out_d;

  assign adv        = !(valid_q[OutStg] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NStg-2:0], in_valid_i};
    end
  end

  always_comb begin
    carry_d.dmode   = in_data_i.operation == lefd_pkg::OpDirection;
    carry_d.zero    = (in_data_i.dir_x == '0) && (in_data_i.dir_y == '0)
                      && (in_data_i.dir_z == '0);
    carry_d.len_pos = !in_data_i.seg_length[31] && (in_data_i.seg_length != '0);
    carry_d.dneg    = {in_data_i.dir_z[31], in_data_i.dir_y[31], in_data_i.dir_x[31]};
    carry_d.st      = {in_data_i.start_z, in_data_i.start_y, in_data_i.start_x};
    carry_d.en      = {in_data_i.end_z, in_data_i.end_y, in_data_i.end_x};
    carry_d.d       = {in_data_i.dir_z, in_data_i.dir_y, in_data_i.dir_x};
    carry_d.len     = in_data_i.seg_length;
  end

  // Carry the side data down the pipe alongside the arithmetic.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      carry_q[0] <= carry_d;
      for (int k = 1; k < NStg; k++) begin
        carry_q[k] <= carry_q[k-1];
      end
    end
  end

  // Front stages: magnitudes, squares and products, then the squared length.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_q[i] <= carry_d.d[i][31] ? (~carry_d.d[i] + 32'd1) : carry_d.d[i];
        sq_q[i] <= {32'd0, a_q[i]} * {32'd0, a_q[i]};
        p1_q[i] <= {31'd0, a_q[i]} * {32'd0, lenu_q};
      end
      lenu_q <= carry_d.len_pos ? carry_d.len[30:0] : '0;
      sxy_q  <= sq_q[0] + sq_q[1];
      sz_q   <= sq_q[2];
      p2_q   <= p1_q;
      s_q    <= sxy_q + sz_q;
      p3_q   <= p2_q;
    end
  end

  // Square root, two result bits a stage.
  for (genvar j = 0; j < SqStg; j++) begin : g_sqrt
    logic [63:0]      v_in, r_in;
    logic [2:0][62:0] p_in;
    logic [63:0]      v_nx, r_nx;
    if (j == 0) begin : g_first
      assign v_in = s_q;
      assign r_in = '0;
      assign p_in = p3_q;
    end else begin : g_rest
      assign v_in = sqv_q[j-1];
      assign r_in = sqr_q[j-1];
      assign p_in = sqp_q[j-1];
    end
    always_comb begin
      logic [63:0] bv;
      v_nx = v_in;
      r_nx = r_in;
      for (int t = 0; t < 2; t++) begin
        bv = 64'd1 << (62 - 2 * (2 * j + t));
        if (v_nx >= r_nx + bv) begin
          v_nx = v_nx - (r_nx + bv);
          r_nx = (r_nx >> 1) + bv;
        end else begin
          r_nx = r_nx >> 1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sqv_q[j] <= v_nx;
        sqr_q[j] <= r_nx;
        sqp_q[j] <= p_in;
      end
    end
  end

  // Numerators with the rounding half added.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q <= sqr_q[SqStg-1][31:0];
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= sqp_q[SqStg-1][i] + {32'd0, sqr_q[SqStg-1][31:1]};
      end
    end
  end

  // Restoring divide, two quotient bits a stage per axis.
  for (genvar j = 0; j < DivStg; j++) begin : g_div
    logic [2:0][31:0] r_in, q_in, r_nx, q_nx;
    logic [2:0][62:0] n_in;
    logic [31:0]      m_in;
    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          r_in[i] = {1'b0, n_q[i][62:32]};
        end
      end
      assign q_in = '0;
      assign n_in = n_q;
      assign m_in = mag_q;
    end else begin : g_rest
      assign r_in = rem_q[j-1];
      assign q_in = quo_q[j-1];
      assign n_in = dn_q[j-1];
      assign m_in = dm_q[j-1];
    end
    always_comb begin
      logic [32:0] r33;
      r_nx = r_in;
      q_nx = q_in;
      r33  = '0;
      for (int i = 0; i < 3; i++) begin
        for (int t = 0; t < 2; t++) begin
          r33 = {r_nx[i], n_in[i][31 - 2 * j - t]};
          if (r33 >= {1'b0, m_in}) begin
            r33     = r33 - {1'b0, m_in};
            q_nx[i] = {q_nx[i][30:0], 1'b1};
          end else begin
            q_nx[i] = {q_nx[i][30:0], 1'b0};
          end
          r_nx[i] = r33[31:0];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[j] <= r_nx;
        quo_q[j] <= q_nx;
        dn_q[j]  <= n_in;
        dm_q[j]  <= m_in;
      end
    end
  end

  // Sign the offset, add, clamp, then choose by mode.
  always_comb begin
    carry_t      c;
    logic [33:0] addend, sum;
    logic [2:0][31:0] ends;
    c = carry_q[OutStg-1];
    for (int i = 0; i < 3; i++) begin
      if (c.len_pos) begin
        addend = c.dneg[i] ? (34'd0 - {2'd0, quo_q[DivStg-1][i]})
                           : {2'd0, quo_q[DivStg-1][i]};
      end else begin
        addend = {{2{c.d[i][31]}}, c.d[i]};
      end
      sum = {{2{c.st[i][31]}}, c.st[i]} + addend;
      if (!sum[33] && (sum[32:31] != 2'b00)) begin
        ends[i] = 32'h7fff_ffff;
      end else if (sum[33] && (sum[32:31] != 2'b11)) begin
        ends[i] = 32'h8000_0000;
      end else begin
        ends[i] = sum[31:0];
      end
      if (!c.dmode) begin
        ends[i] = c.en[i];
      end else if (c.zero) begin
        ends[i] = c.st[i];
      end
    end
    out_d.out_start_x = c.st[0];
    out_d.out_start_y = c.st[1];
    out_d.out_start_z = c.st[2];
    out_d.out_end_x   = ends[0];
    out_d.out_end_y   = ends[1];
    out_d.out_end_z   = ends[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q[OutStg];
  assign out_data_o  = out_q;

  // Remainder of the root never exceeds twice the root.
  a_sqrt_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NumStg-1] |-> (sqv_q[SqStg-1] <= {sqr_q[SqStg-1][62:0], 1'b0}))
    else $error("square root remainder out of range");

  // Scaled x offset never exceeds the wanted length.
  a_quo_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[OutStg-1] && carry_q[OutStg-1].dmode && carry_q[OutStg-1].len_pos
     && !carry_q[OutStg-1].zero)
    |-> ({1'b0, quo_q[DivStg-1][0]} <= {1'b0, carry_q[OutStg-1].len}))
    else $error("divider quotient exceeds length");

  // A held output word keeps the pipe frozen behind it.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (valid_q == $past(valid_q)))
    else $error("pipeline moved while output stalled");

endmodule

// ===== bench/tb.sv =====
// Testbench for the line end point builder: directed and random words against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int CyclesMax = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  lefd_pkg::in_word_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  lefd_pkg::out_word_t out_data_o;

  lefd_pkg::out_word_t expected_lines[$];
  int        fault_count = 0;
  int        cycle_count = 0;
  int        rx_wait = 0;
  bit        rx_random = 1'b0;
  bit        rx_hold = 1'b0;

  line_endpoint_from_direction uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CyclesMax) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic signed [31:0] clamp_coord(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic lefd_pkg::out_word_t line_ends(input lefd_pkg::in_word_t w);
    lefd_pkg::out_word_t r;
    longint st[3], en[3], d[3];
    longint len;
    logic [63:0] sq, mag, a, q;
    longint off;
    st = '{longint'(w.start_x), longint'(w.start_y), longint'(w.start_z)};
    en = '{longint'(w.end_x), longint'(w.end_y), longint'(w.end_z)};
    d  = '{longint'(w.dir_x), longint'(w.dir_y), longint'(w.dir_z)};
    len = longint'(w.seg_length);
    if (w.operation == lefd_pkg::OpDirection) begin
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        a = d[i] < 0 ? -d[i] : d[i];
        sq = sq + a * a;
      end
      if (sq == 0) begin
        en = st;
      end else if (len <= 0) begin
        for (int i = 0; i < 3; i++) en[i] = clamp_coord(st[i] + d[i]);
      end else begin
        mag = floor_root(sq);
        for (int i = 0; i < 3; i++) begin
          a = d[i] < 0 ? -d[i] : d[i];
          q = (a * len + mag / 2) / mag;
          off = d[i] < 0 ? -longint'(q) : longint'(q);
          en[i] = clamp_coord(st[i] + off);
        end
      end
    end
    r.out_start_x = st[0][31:0];
    r.out_start_y = st[1][31:0];
    r.out_start_z = st[2][31:0];
    r.out_end_x = en[0][31:0];
    r.out_end_y = en[1][31:0];
    r.out_end_z = en[2][31:0];
    return r;
  endfunction

  // Receiver: in random mode draw a wait after each taken word, or hold for a long stretch when asked.
  always @(posedge clk_i) begin
    if (rx_hold) begin
      out_stall_i <= 1'b1;
    end else if (!rx_random) begin
      out_stall_i <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      rx_wait = $urandom_range(0, 17);
      out_stall_i <= (rx_wait != 0);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      out_stall_i <= (rx_wait != 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    lefd_pkg::out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_lines.size() == 0) begin
        $error("result word with none expected: %h", out_data_o);
        fault_count++;
      end else begin
        e = expected_lines.pop_front();
        if (out_data_o.out_start_x !== e.out_start_x) begin
          $error("out_start_x exp %h got %h", e.out_start_x, out_data_o.out_start_x);
          fault_count++;
        end
        if (out_data_o.out_start_y !== e.out_start_y) begin
          $error("out_start_y exp %h got %h", e.out_start_y, out_data_o.out_start_y);
          fault_count++;
        end
        if (out_data_o.out_start_z !== e.out_start_z) begin
          $error("out_start_z exp %h got %h", e.out_start_z, out_data_o.out_start_z);
          fault_count++;
        end
        if (out_data_o.out_end_x !== e.out_end_x) begin
          $error("out_end_x exp %h got %h", e.out_end_x, out_data_o.out_end_x);
          fault_count++;
        end
        if (out_data_o.out_end_y !== e.out_end_y) begin
          $error("out_end_y exp %h got %h", e.out_end_y, out_data_o.out_end_y);
          fault_count++;
        end
        if (out_data_o.out_end_z !== e.out_end_z) begin
          $error("out_end_z exp %h got %h", e.out_end_z, out_data_o.out_end_z);
          fault_count++;
        end
      end
    end
  end

  // Drop valid only across a gap, so back-to-back words see a single drive per edge.
  task automatic send_word(input lefd_pkg::in_word_t w, input int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_lines.push_back(line_ends(w));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom_range(0, 2) - 1;
      3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic lefd_pkg::in_word_t rand_word();
    lefd_pkg::in_word_t w;
    w.operation = ($urandom_range(0, 3) != 0) ? lefd_pkg::OpDirection : lefd_pkg::OpTwoPoint;
    w.start_x = rand_coord(); w.start_y = rand_coord(); w.start_z = rand_coord();
    w.end_x = rand_coord(); w.end_y = rand_coord(); w.end_z = rand_coord();
    w.dir_x = rand_coord(); w.dir_y = rand_coord(); w.dir_z = rand_coord();
    if ($urandom_range(0, 7) == 0) begin
      w.dir_x = 0; w.dir_y = 0; w.dir_z = 0;
    end
    w.seg_length = rand_coord();
    return w;
  endfunction

  function automatic lefd_pkg::in_word_t make_word(input logic op, input logic [31:0] s,
                                                   input logic [31:0] e,
                                                   input logic [31:0] d,
                                                   input logic [31:0] l);
    lefd_pkg::in_word_t w;
    w.operation = op;
    w.start_x = s; w.start_y = -s; w.start_z = s ^ 32'h1;
    w.end_x = e; w.end_y = ~e; w.end_z = e;
    w.dir_x = d; w.dir_y = -d; w.dir_z = d >>> 1;
    w.seg_length = l;
    return w;
  endfunction

  task automatic test_directed();
    send_word(make_word(lefd_pkg::OpTwoPoint, 32'h80000000, 32'h7fffffff, 32'h1, 32'h1), 0);
    send_word(make_word(lefd_pkg::OpTwoPoint, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0), 0);
    send_word(make_word(lefd_pkg::OpDirection, 32'h00010000, 32'h5, 32'h0, 32'h00020000), 1);
    send_word(make_word(lefd_pkg::OpDirection, 32'h00010000, 32'h5, 32'h00010000, 32'h0), 1);
    send_word(make_word(lefd_pkg::OpDirection, 32'h00010000, 32'h5, 32'h00010000,
                        32'h80000000), 0);
    send_word(make_word(lefd_pkg::OpDirection, 32'h00010000, 32'h5, 32'h00010000,
                        32'h00030000), 0);
    send_word(make_word(lefd_pkg::OpDirection, 32'h7fffffff, 0, 32'h7fffffff, 32'h0), 2);
    send_word(make_word(lefd_pkg::OpDirection, 32'h80000000, 0, 32'h80000000, 32'h0), 0);
    send_word(make_word(lefd_pkg::OpDirection, 32'h7fffffff, 0, 32'h80000000,
                        32'h7fffffff), 0);
    send_word(make_word(lefd_pkg::OpDirection, 32'h80000000, 0, 32'h1, 32'h7fffffff), 0);
    send_word(make_word(lefd_pkg::OpDirection, 32'h0, 0, 32'h80000000, 32'h1), 0);
    send_word(make_word(lefd_pkg::OpDirection, 32'h0, 0, 32'h3, 32'h2), 0);
    send_word(make_word(lefd_pkg::OpDirection, 32'hffffffff, 0, 32'hffffffff,
                        32'h7fffffff), 0);
  endtask

  task automatic test_random(input int n);
    rx_random = 1'b1;
    for (int i = 0; i < n; i++) send_word(rand_word(), (i % 50 < 10) ? 0 : 17);
  endtask

  task automatic test_backpressure();
    // hold the output long enough for the pipeline to fill and stall its input
    fork
      begin
        rx_hold = 1'b1;
        repeat (120) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 60; i++) send_word(rand_word(), 0);
    join
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(330);
    in_valid_i <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fault_count == 0 && expected_lines.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lefd_pkg.sv
sv/line_endpoint_from_direction.sv
bench/tb.sv
